>>> rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants for the 3x3 fixed-point matrix inverse unit.
// ----------------------------------------------------------------------------
`default_nettype none

package m3i_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] ADDR_SINGULAR_MODE = 2'd0;

  localparam logic MODE_ADJUGATE = 1'b0;
  localparam logic MODE_IDENTITY = 1'b1;

endpackage

`default_nettype wire

>>> rtl/m3i_front.sv
// ----------------------------------------------------------------------------
// m3i_front
// Accepts a matrix, forms the nine cofactors and the exact determinant.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_front #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [9*WORD_BITS-1:0]   in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [9*(2*WORD_BITS+1)+3*WORD_BITS+1:0] out_data_o
);

  localparam int W  = WORD_BITS;
  localparam int AW = 2*W + 1;
  localparam int DW = 3*W + 2;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [W-1:0]    a      [3][3];
  logic signed [2*W-1:0]  p0_q   [3][3];
  logic signed [2*W-1:0]  p1_q   [3][3];
  logic signed [W-1:0]    col1_q [3];
  logic signed [AW-1:0]   adj2_q [3][3];
  logic signed [W-1:0]    col2_q [3];
  logic signed [AW-1:0]   adj3_q [3][3];
  logic signed [AW-1:0]   lo_q   [3];
  logic signed [AW-1:0]   hi_q   [3];
  logic signed [AW-1:0]   adj4_q [3][3];
  logic signed [DW-1:0]   det_q;

  assign en          = !(v4_q && !out_ready_i);
  assign in_ready_o  = en;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  for (genvar gr = 0; gr < 3; gr++) begin : g_row
    for (genvar gc = 0; gc < 3; gc++) begin : g_col
      localparam int R1 = (gc + 1) % 3;
      localparam int R2 = (gc + 2) % 3;
      localparam int C1 = (gr + 1) % 3;
      localparam int C2 = (gr + 2) % 3;

      assign a[gr][gc] = $signed(in_data_i[(3*gr+gc)*W +: W]);

      always_ff @(posedge clk_i) begin
        if (en) begin
          p0_q[gr][gc]   <= a[R1][C1] * a[R2][C2];
          p1_q[gr][gc]   <= a[R1][C2] * a[R2][C1];
          adj2_q[gr][gc] <= AW'(p0_q[gr][gc]) - AW'(p1_q[gr][gc]);
          adj3_q[gr][gc] <= adj2_q[gr][gc];
          adj4_q[gr][gc] <= adj3_q[gr][gc];
        end
      end

      assign out_data_o[(3*gr+gc)*AW +: AW] = adj4_q[gr][gc];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        col1_q[gr] <= a[gr][0];
        col2_q[gr] <= col1_q[gr];
        lo_q[gr]   <= col2_q[gr] * $signed({1'b0, adj2_q[0][gr][W-1:0]});
        hi_q[gr]   <= col2_q[gr] * $signed(adj2_q[0][gr][AW-1:W]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= (DW'(hi_q[0]) <<< W) + DW'(lo_q[0])
             + (DW'(hi_q[1]) <<< W) + DW'(lo_q[1])
             + (DW'(hi_q[2]) <<< W) + DW'(lo_q[2]);
    end
  end

  assign out_data_o[9*AW +: DW] = det_q;

endmodule

`default_nettype wire

>>> rtl/m3i_queue.sv
// ----------------------------------------------------------------------------
// m3i_queue
// Short register queue between the cofactor front and the divider back.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = m3i_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [WIDTH-1:0]      out_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CW'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CW'(DEPTH)) |-> wr_q == rd_q)
    else $error("queue pointers disagree with count");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

>>> rtl/m3i_back.sv
// ----------------------------------------------------------------------------
// m3i_back
// Restoring divider pipeline, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_back #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS,
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   mode_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [9*(2*WORD_BITS+1)+3*WORD_BITS+1:0] in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [9*WORD_BITS-1:0]      out_data_o,
  output logic                        out_singular_o,
  output logic                        out_saturated_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int AW = 2*W + 1;
  localparam int DW = 3*W + 2;
  localparam int QW = W + 1;
  localparam int SW = ((AW + 2*F) > (DW + W)) ? (AW + 2*F) : (DW + W);
  localparam int NS = W + 1;
  localparam logic [QW-1:0] HALF = QW'(1) << (W - 1);

  logic en;

  logic [SW-1:0] rem_s [NS][9];
  logic [QW-1:0] q_s   [NS][9];
  logic          neg_s [NS][9];
  logic [DW-1:0] dm_s  [NS];
  logic          sg_s  [NS];
  logic          ps_s  [NS];
  logic          v_s   [NS];

  logic [SW-1:0] rem_q [NS][9];
  logic [QW-1:0] q_q   [NS][9];
  logic          neg_q [NS][9];
  logic [DW-1:0] dm_q  [NS];
  logic          sg_q  [NS];
  logic          ps_q  [NS];
  logic          v_q   [NS];

  logic signed [DW-1:0] e_det;
  logic                 e_dneg, e_sing;
  logic [DW-1:0]        e_dmag;
  logic [8:0]           e_psat;

  logic                 out_v_q;
  logic [9*W-1:0]       out_d_q;
  logic                 out_sg_q, out_st_q;
  logic [9*W-1:0]       fin_d;
  logic [8:0]           fin_sat;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  assign e_det  = $signed(in_data_i[9*AW +: DW]);
  assign e_dneg = e_det[DW-1];
  assign e_dmag = e_dneg ? DW'(-e_det) : DW'(e_det);
  assign e_sing = (e_det == '0);

  for (genvar l = 0; l < 9; l++) begin : g_entry
    logic signed [AW-1:0] adj;
    logic                 aneg, lneg;
    logic [AW-1:0]        amag, m0;
    logic [QW-1:0]        lim;

    assign adj  = $signed(in_data_i[l*AW +: AW]);
    assign aneg = adj[AW-1];
    assign amag = aneg ? AW'(-adj) : AW'(adj);

    always_comb begin
      if (!e_sing) begin
        lneg = aneg ^ e_dneg;
      end else if (mode_i == m3i_pkg::MODE_IDENTITY) begin
        lneg = 1'b0;
      end else begin
        lneg = aneg;
      end
      lim = lneg ? HALF : HALF - 1'b1;
      if (mode_i == m3i_pkg::MODE_IDENTITY) begin
        m0 = ((l / 3) == (l % 3)) ? (AW'(1) << F) : '0;
      end else begin
        m0 = amag >> F;
      end
      rem_s[0][l] = e_sing ? '0 : (SW'(amag) << (2*F));
      neg_s[0][l] = lneg;
      e_psat[l]   = 1'b0;
      q_s[0][l]   = '0;
      if (e_sing) begin
        if (m0 > AW'(lim)) begin
          q_s[0][l] = lim;
          e_psat[l] = 1'b1;
        end else begin
          q_s[0][l] = m0[QW-1:0];
        end
      end
    end
  end

  assign dm_s[0] = e_dmag;
  assign sg_s[0] = e_sing;
  assign ps_s[0] = |e_psat;
  assign v_s[0]  = in_valid_i;

  for (genvar j = 1; j < NS; j++) begin : g_link
    for (genvar l = 0; l < 9; l++) begin : g_lane
      assign rem_s[j][l] = rem_q[j-1][l];
      assign q_s[j][l]   = q_q[j-1][l];
      assign neg_s[j][l] = neg_q[j-1][l];
    end
    assign dm_s[j] = dm_q[j-1];
    assign sg_s[j] = sg_q[j-1];
    assign ps_s[j] = ps_q[j-1];
    assign v_s[j]  = v_q[j-1];
  end

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int K = W - j;
    logic [SW-1:0] dsh;

    assign dsh = SW'(dm_s[j]) << K;

    for (genvar l = 0; l < 9; l++) begin : g_lane
      logic ge;
      assign ge = !sg_s[j] && (rem_s[j][l] >= dsh);
      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[j][l] <= ge ? rem_s[j][l] - dsh : rem_s[j][l];
          q_q[j][l]   <= q_s[j][l] | (ge ? (QW'(1) << K) : '0);
          neg_q[j][l] <= neg_s[j][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dm_q[j] <= dm_s[j];
        sg_q[j] <= sg_s[j];
        ps_q[j] <= ps_s[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= v_s[j];
      end
    end
  end

  for (genvar l = 0; l < 9; l++) begin : g_fin
    logic [QW-1:0] q, lim;
    logic          n;
    assign q   = q_q[NS-1][l];
    assign n   = neg_q[NS-1][l];
    assign lim = n ? HALF : HALF - 1'b1;
    assign fin_sat[l] = (q > lim);
    always_comb begin
      if (fin_sat[l]) begin
        fin_d[l*W +: W] = n ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else if (n) begin
        fin_d[l*W +: W] = ~q[W-1:0] + 1'b1;
      end else begin
        fin_d[l*W +: W] = q[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_d_q  <= fin_d;
      out_sg_q <= sg_q[NS-1];
      out_st_q <= ps_q[NS-1] | (|fin_sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v_q[NS-1];
    end
  end

  assign out_valid_o     = out_v_q;
  assign out_data_o      = out_d_q;
  assign out_singular_o  = out_sg_q;
  assign out_saturated_o = out_st_q;

endmodule

`default_nettype wire

>>> rtl/mat3_inverse_unit.sv
// ----------------------------------------------------------------------------
// mat3_inverse_unit
// 3x3 Q16.16 matrix inverse by the adjugate with a pipelined exact divider.
// Datapath: the four-stage cofactor front, the queue register, the
//   one-bit-per-stage divider pipeline and the output register.
// Throughput: one matrix per cycle while the output side keeps taking.
// Reset: clears all valid state; singular_mode resets to adjugate output.
// ----------------------------------------------------------------------------
`default_nettype none

module mat3_inverse_unit #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS,
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // in_r1c1, in_r1c2, in_r1c3, in_r2c1, ..., in_r3c3 from bit 0 up
  input  wire logic [((9*WORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // out_r1c1, out_r1c2, out_r1c3, out_r2c1, ..., out_r3c3 from bit 0 up
  output logic [((9*WORD_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // singular, saturated from bit 0 up
  output logic [1:0]                     m_axis_tuser_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [m3i_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [m3i_pkg::APB_DATA_W-1:0] pwdata,
  output logic [m3i_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int W  = WORD_BITS;
  localparam int TW = ((9*W+7)/8)*8;
  localparam int PW = 9*(2*W+1) + 3*W + 2;

  logic          mode_q;
  logic          f_valid, f_ready, b_valid, b_ready;
  logic [PW-1:0] f_data, b_data;
  logic [9*W-1:0] o_data;
  logic          o_sing, o_sat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= m3i_pkg::MODE_ADJUGATE;
    end else if (psel && penable && pwrite && pready &&
                 paddr == m3i_pkg::ADDR_SINGULAR_MODE) begin
      mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr == m3i_pkg::ADDR_SINGULAR_MODE) ?
                  m3i_pkg::APB_DATA_W'(mode_q) : '0;

  m3i_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i[9*W-1:0]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  m3i_queue #(
    .WIDTH (PW),
    .DEPTH (m3i_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_data),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_data_o  (b_data)
  );

  m3i_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_q),
    .in_valid_i      (b_valid),
    .in_ready_o      (b_ready),
    .in_data_i       (b_data),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_data_o      (o_data),
    .out_singular_o  (o_sing),
    .out_saturated_o (o_sat)
  );

  assign m_axis_tdata_o = TW'(o_data);
  assign m_axis_tuser_o = {o_sat, o_sing};

endmodule

`default_nettype wire
